FILE: rtl/tlbpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpe_pkg : shared definitions of the three led blink pattern engine
// mode codes, register indexes, led selectors and the structs passed between
// the request decoder and the per-led channels
// ----------------------------------------------------------------------------
package tlbpe_pkg;

   localparam int COUNT_BITS_DEF = 8;
   localparam int MODE_W         = 4;
   localparam int PHASE_W        = 8;
   localparam int PAIR_W         = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 8;
   localparam int NUM_LEDS       = 3;

   // blink modes
   localparam logic [MODE_W-1:0] MODE_OFF      = 4'd0;
   localparam logic [MODE_W-1:0] MODE_STEADY   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_BLINK    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_P250     = 4'd3;
   localparam logic [MODE_W-1:0] MODE_P1S      = 4'd4;
   localparam logic [MODE_W-1:0] MODE_P3S      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_P5S      = 4'd6;
   localparam logic [MODE_W-1:0] MODE_TWICE    = 4'd7;
   localparam logic [MODE_W-1:0] MODE_TICKTOCK = 4'd8;
   localparam logic [MODE_W-1:0] MODE_P80      = 4'd9;
   localparam logic [MODE_W-1:0] MODE_OFFP5S   = 4'd10;

   // led selectors
   localparam logic [1:0] LED_POSITION = 2'd0;
   localparam logic [1:0] LED_SYSTEM   = 2'd1;
   localparam logic [1:0] LED_CELLULAR = 2'd2;

   // system states carried by a tick
   localparam logic [1:0] SYS_RUNNING = 2'd0;
   localparam logic [1:0] SYS_SLEEP   = 2'd1;
   localparam logic [1:0] SYS_BATTERY = 2'd2;

   // transaction opcodes
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_SET_MODE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ON_SHORT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_SHORT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUARTER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_ONE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_THREE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_FIVE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_FIVE    = 3'd7;

   localparam logic [PAIR_W-1:0] PAIR_END = 2'd2;

   typedef struct packed {
      logic [PHASE_W-1:0] on_short;
      logic [PHASE_W-1:0] off_short;
      logic [PHASE_W-1:0] quarter;
      logic [PHASE_W-1:0] half;
      logic [PHASE_W-1:0] off_one;
      logic [PHASE_W-1:0] off_three;
      logic [PHASE_W-1:0] off_five;
      logic [PHASE_W-1:0] on_five;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PHASE_W-1:0] phase;
      logic               level;
      logic [PAIR_W-1:0]  pair;
   } led_state_type;

   // one led's share of a transaction
   typedef struct packed {
      logic              req_valid;   // mode request for this led
      logic [MODE_W-1:0] req_mode;    // mode as asked, compared with the current one
      logic              force_on;    // cellular override replaces the mode by steady
      logic              tt_load;     // ticktock here reloads level and phase
      logic              fan_valid;   // ticktock launched on the position led
      logic              fan_level;
      logic              tick;        // advance after the request
   } led_req_type;

endpackage : tlbpe_pkg
`default_nettype wire

FILE: rtl/tlbpe_req_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpe_req_decode : splits one transaction into per-led requests
// applies the system state rules of a tick and the ticktock fan-out
// ----------------------------------------------------------------------------
module tlbpe_req_decode (
   input  wire logic                        op,
   input  wire logic [1:0]                  led_select,
   input  wire logic [tlbpe_pkg::MODE_W-1:0] mode_request,
   input  wire logic [1:0]                  system_mode,
   input  wire logic                        error_flag,
   input  wire logic                        server_ok,
   input  wire logic [tlbpe_pkg::MODE_W-1:0] position_mode,
   output tlbpe_pkg::led_req_type           pos_req,
   output tlbpe_pkg::led_req_type           sys_req,
   output tlbpe_pkg::led_req_type           cell_req
);
   import tlbpe_pkg::*;

   logic set_ok;
   logic is_tick;
   logic fan;

   always_comb begin
      is_tick = (op == OP_TICK);
      set_ok  = (op == OP_SET_MODE) && (led_select <= LED_CELLULAR)
                && (mode_request <= MODE_OFFP5S);
      fan     = set_ok && (led_select == LED_POSITION) && (mode_request == MODE_TICKTOCK)
                && (position_mode != MODE_TICKTOCK);

      pos_req  = '0;
      sys_req  = '0;
      cell_req = '0;

      pos_req.tick  = is_tick;
      sys_req.tick  = is_tick;
      cell_req.tick = is_tick;

      pos_req.tt_load = 1'b1;
      cell_req.force_on = (system_mode == SYS_RUNNING) && server_ok;

      sys_req.fan_valid  = fan;
      sys_req.fan_level  = 1'b1;
      cell_req.fan_valid = fan;
      cell_req.fan_level = 1'b0;

      if (is_tick) begin
         // position and cellular go dark in sleep and battery
         if ((system_mode == SYS_SLEEP) || (system_mode == SYS_BATTERY)) begin
            pos_req.req_valid  = 1'b1;
            pos_req.req_mode   = MODE_OFF;
            cell_req.req_valid = 1'b1;
            cell_req.req_mode  = MODE_OFF;
         end
         if (error_flag) begin
            sys_req.req_valid = 1'b1;
            sys_req.req_mode  = MODE_P80;
         end else begin
            unique case (system_mode)
               SYS_RUNNING: begin
                  sys_req.req_valid = 1'b1;
                  sys_req.req_mode  = MODE_OFF;
               end
               SYS_SLEEP: begin
                  sys_req.req_valid = 1'b1;
                  sys_req.req_mode  = MODE_P3S;
               end
               SYS_BATTERY: begin
                  sys_req.req_valid = 1'b1;
                  sys_req.req_mode  = MODE_STEADY;
               end
               default: begin
                  sys_req.req_valid = 1'b0;
               end
            endcase
         end
      end else if (set_ok) begin
         unique case (led_select)
            LED_POSITION: begin
               pos_req.req_valid = 1'b1;
               pos_req.req_mode  = mode_request;
            end
            LED_SYSTEM: begin
               sys_req.req_valid = 1'b1;
               sys_req.req_mode  = mode_request;
            end
            default: begin
               cell_req.req_valid = 1'b1;
               cell_req.req_mode  = mode_request;
            end
         endcase
      end
   end

endmodule : tlbpe_req_decode
`default_nettype wire

FILE: rtl/tlbpe_led_channel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpe_led_channel : state and update of one led
// a mode request first, then one tick of the phase counter
// ----------------------------------------------------------------------------
module tlbpe_led_channel #(
   parameter int COUNT_BITS = tlbpe_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  update_en,
   input  wire tlbpe_pkg::cfg_type    cfg,
   input  wire tlbpe_pkg::led_req_type req,
   output tlbpe_pkg::led_state_type   state,
   output logic                       level_next
);
   import tlbpe_pkg::*;

   localparam int CMP_W = (COUNT_BITS > PHASE_W) ? COUNT_BITS : PHASE_W;

   led_state_type          state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   led_state_type          s_req;
   logic [COUNT_BITS-1:0]  c_req;
   logic [COUNT_BITS-1:0]  c_inc;
   logic                   phase_done;
   logic [MODE_W-1:0]      new_mode;

   always_comb begin
      // mode request
      s_req    = state_ff;
      c_req    = count_ff;
      new_mode = req.force_on ? MODE_STEADY : req.req_mode;
      if (req.req_valid && (req.req_mode != state_ff.mode)) begin
         s_req.mode = new_mode;
         c_req      = '0;
         unique case (new_mode)
            MODE_OFF: begin
               s_req.level = 1'b0;
               s_req.phase = '0;
            end
            MODE_STEADY: begin
               s_req.level = 1'b1;
               s_req.phase = '0;
            end
            MODE_BLINK: begin
               s_req.level = 1'b1;
               s_req.phase = cfg.half;
            end
            MODE_P250: begin
               s_req.level = 1'b0;
               s_req.phase = cfg.quarter;
            end
            MODE_P1S: begin
               s_req.level = 1'b0;
               s_req.phase = cfg.off_one;
            end
            MODE_P3S: begin
               s_req.level = 1'b0;
               s_req.phase = cfg.off_three;
            end
            MODE_P5S: begin
               s_req.level = 1'b0;
               s_req.phase = cfg.off_five;
            end
            MODE_TWICE, MODE_P80: begin
               s_req.level = 1'b0;
               s_req.phase = cfg.off_short;
            end
            MODE_OFFP5S: begin
               s_req.level = 1'b1;
               s_req.phase = cfg.on_five;
            end
            MODE_TICKTOCK: begin
               // only the position led restarts its phase
               if (req.tt_load) begin
                  s_req.level = 1'b0;
                  s_req.phase = cfg.quarter;
               end
            end
            default: begin
               s_req.level = s_req.level;
            end
         endcase
      end else if (req.fan_valid) begin
         s_req.mode  = MODE_TICKTOCK;
         s_req.level = req.fan_level;
         s_req.phase = cfg.quarter;
      end

      // tick advance
      state_in   = s_req;
      count_in   = c_req;
      c_inc      = c_req + 1'b1;
      phase_done = !(CMP_W'(c_inc) < CMP_W'(s_req.phase)) || (&c_inc);
      if (req.tick) begin
         if (s_req.mode == MODE_OFF) begin
            state_in.level = 1'b0;
         end else if (s_req.mode == MODE_STEADY) begin
            state_in.level = 1'b1;
         end else if (!phase_done) begin
            count_in = c_inc;
         end else begin
            count_in       = '0;
            state_in.level = !s_req.level;
            unique case (s_req.mode)
               MODE_P250:
                  state_in.phase = state_in.level ? cfg.on_short : cfg.quarter;
               MODE_P1S:
                  state_in.phase = state_in.level ? cfg.on_short : cfg.off_one;
               MODE_P3S:
                  state_in.phase = state_in.level ? cfg.on_short : cfg.off_three;
               MODE_P5S:
                  state_in.phase = state_in.level ? cfg.on_short : cfg.off_five;
               MODE_P80:
                  state_in.phase = state_in.level ? cfg.on_short : cfg.off_short;
               MODE_TICKTOCK:
                  state_in.phase = cfg.quarter;
               MODE_OFFP5S:
                  state_in.phase = state_in.level ? cfg.on_five : cfg.on_short;
               MODE_TWICE: begin
                  state_in.phase = cfg.on_short;
                  if (state_in.level) begin
                     state_in.pair = s_req.pair + 1'b1;
                  end else if (s_req.pair == PAIR_END) begin
                     // second flash done, long gap
                     state_in.pair  = '0;
                     state_in.phase = cfg.off_one;
                  end
               end
               default: begin
                  state_in.phase = s_req.phase;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode  <= MODE_OFF;
         state_ff.phase <= '0;
         state_ff.level <= 1'b0;
         state_ff.pair  <= '0;
         count_ff       <= '0;
      end else if (update_en) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign state      = state_ff;
   assign level_next = state_in.level;

endmodule : tlbpe_led_channel
`default_nettype wire

FILE: rtl/three_led_blink_pattern_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_led_blink_pattern_engine_top : status led blink pattern engine
// drives the position, system and cellular leds from tick and set-mode
// transactions, phase lengths taken from eight duration registers
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  op, led_select, mode_request,
//                                             system_mode, error_flag, server_ok
//   rsp       out        rsp_valid/rsp_stall  position/system/cellular_led_on
//   csr       in         csr_write            csr_index, csr_wdata
//
// one transaction per cycle sustained while no result is held; each passes the input
// register, then the led update into the result register
// every transaction gives exactly one result with the three levels after it
// req_stall rises only while a result waits and rsp_stall holds it
// reset clears all led state and loads the default durations, no clearing pass
// ----------------------------------------------------------------------------
module three_led_blink_pattern_engine_top #(
   parameter int COUNT_BITS = tlbpe_pkg::COUNT_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [1:0]                        req_led_select,
   input  wire logic [tlbpe_pkg::MODE_W-1:0]      req_mode_request,
   input  wire logic [1:0]                        req_system_mode,
   input  wire logic                              req_error_flag,
   input  wire logic                              req_server_ok,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_position_led_on,
   output logic                                   rsp_system_led_on,
   output logic                                   rsp_cellular_led_on,
   // register write port
   input  wire logic                              csr_write,
   input  wire logic [tlbpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tlbpe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tlbpe_pkg::*;

   // duration registers
   cfg_type cfg_ff;

   // input register
   logic              in_valid_ff;
   logic              op_ff;
   logic [1:0]        sel_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [1:0]        sys_ff;
   logic              err_ff;
   logic              srv_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              pos_on_ff, sys_on_ff, cell_on_ff;

   logic              out_ready;
   logic              update_en;
   logic              req_accept;

   led_req_type       pos_req, sys_req, cell_req;
   led_state_type     pos_state, sys_state, cell_state;
   logic              pos_next, sys_next, cell_next;

   // result slot is free or being emptied this cycle
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign update_en  = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_short  <= 8'd8;
         cfg_ff.off_short <= 8'd8;
         cfg_ff.quarter   <= 8'd25;
         cfg_ff.half      <= 8'd50;
         cfg_ff.off_one   <= 8'd100;
         cfg_ff.off_three <= 8'd255;
         cfg_ff.off_five  <= 8'd255;
         cfg_ff.on_five   <= 8'd255;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ON_SHORT:  cfg_ff.on_short  <= csr_wdata;
            CSR_OFF_SHORT: cfg_ff.off_short <= csr_wdata;
            CSR_QUARTER:   cfg_ff.quarter   <= csr_wdata;
            CSR_HALF:      cfg_ff.half      <= csr_wdata;
            CSR_OFF_ONE:   cfg_ff.off_one   <= csr_wdata;
            CSR_OFF_THREE: cfg_ff.off_three <= csr_wdata;
            CSR_OFF_FIVE:  cfg_ff.off_five  <= csr_wdata;
            default:       cfg_ff.on_five   <= csr_wdata;
         endcase
      end
   end

   // input stage refills whenever it is not held
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_op;
         sel_ff  <= req_led_select;
         mode_ff <= req_mode_request;
         sys_ff  <= req_system_mode;
         err_ff  <= req_error_flag;
         srv_ff  <= req_server_ok;
      end
   end

   tlbpe_req_decode u_decode (
      .op            (op_ff),
      .led_select    (sel_ff),
      .mode_request  (mode_ff),
      .system_mode   (sys_ff),
      .error_flag    (err_ff),
      .server_ok     (srv_ff),
      .position_mode (pos_state.mode),
      .pos_req       (pos_req),
      .sys_req       (sys_req),
      .cell_req      (cell_req)
   );

   tlbpe_led_channel #(.COUNT_BITS(COUNT_BITS)) u_pos (
      .clock      (clock),
      .reset      (reset),
      .update_en  (update_en),
      .cfg        (cfg_ff),
      .req        (pos_req),
      .state      (pos_state),
      .level_next (pos_next)
   );

   tlbpe_led_channel #(.COUNT_BITS(COUNT_BITS)) u_sys (
      .clock      (clock),
      .reset      (reset),
      .update_en  (update_en),
      .cfg        (cfg_ff),
      .req        (sys_req),
      .state      (sys_state),
      .level_next (sys_next)
   );

   tlbpe_led_channel #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clock      (clock),
      .reset      (reset),
      .update_en  (update_en),
      .cfg        (cfg_ff),
      .req        (cell_req),
      .state      (cell_state),
      .level_next (cell_next)
   );

   // result register, loaded with the levels left by the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update_en) begin
         pos_on_ff  <= pos_next;
         sys_on_ff  <= sys_next;
         cell_on_ff <= cell_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position_led_on = pos_on_ff;
   assign rsp_system_led_on   = sys_on_ff;
   assign rsp_cellular_led_on = cell_on_ff;

`ifndef SYNTHESIS
   // input stage only waits behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled without a held result");

   // a transaction leaving the input stage always shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      update_en |=> rsp_valid_ff)
      else $error("transaction lost between input and result register");

   // off leds are dark and steady leds are lit at all times
   assert property (@(posedge clock) disable iff (reset)
      !((pos_state.mode == MODE_OFF) && pos_state.level) &&
      !((sys_state.mode == MODE_OFF) && sys_state.level) &&
      !((cell_state.mode == MODE_OFF) && cell_state.level) &&
      !((pos_state.mode == MODE_STEADY) && !pos_state.level) &&
      !((sys_state.mode == MODE_STEADY) && !sys_state.level) &&
      !((cell_state.mode == MODE_STEADY) && !cell_state.level))
      else $error("led level disagrees with off or steady mode");

   // a held result keeps its levels
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable({pos_on_ff, sys_on_ff, cell_on_ff}))
      else $error("held result changed");
`endif

endmodule : three_led_blink_pattern_engine_top
`default_nettype wire

FILE: tb/tb_three_led_blink_pattern_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_led_blink_pattern_engine_top : self-checking bench of the led engine
// a queued driver feeds tick and set-mode transactions, a behavioral model of
// the three leds predicts every result and a monitor checks each one; several
// duration settings are loaded between phases while the engine is idle
// ----------------------------------------------------------------------------
module tb_three_led_blink_pattern_engine_top;
   import tlbpe_pkg::*;

   localparam int          CB          = COUNT_BITS_DEF;
   localparam int          QUIET_LIMIT = 2000;  // cycles with no handshake at all
   localparam int          SHOW_LIMIT  = 10;
   localparam logic [1:0]  SYS_OTHER   = 2'd3;  // tick state without any state rule, only the error rule applies
   localparam logic [1:0]  LED_NONE    = 2'd3;  // selector that names no led

   typedef struct packed {
      logic              op;
      logic [1:0]        sel;
      logic [MODE_W-1:0] mode;
      logic [1:0]        sys;
      logic              err;
      logic              srv;
   } stim_item_type;

   typedef struct packed {
      logic pos_on;
      logic sys_on;
      logic cell_on;
   } led_levels_type;

   // dut connections, all inputs known from time zero
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_op           = OP_TICK;
   logic [1:0]            req_led_select   = LED_POSITION;
   logic [MODE_W-1:0]     req_mode_request = MODE_OFF;
   logic [1:0]            req_system_mode  = SYS_RUNNING;
   logic                  req_error_flag   = 1'b0;
   logic                  req_server_ok    = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic                  rsp_position_led_on;
   logic                  rsp_system_led_on;
   logic                  rsp_cellular_led_on;
   logic                  csr_write        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_ON_SHORT;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   three_led_blink_pattern_engine_top #(
      .COUNT_BITS (CB)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_led_select      (req_led_select),
      .req_mode_request    (req_mode_request),
      .req_system_mode     (req_system_mode),
      .req_error_flag      (req_error_flag),
      .req_server_ok       (req_server_ok),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_position_led_on (rsp_position_led_on),
      .rsp_system_led_on   (rsp_system_led_on),
      .rsp_cellular_led_on (rsp_cellular_led_on),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // led model: its own copy of the durations and the per-led state
   // ---------------------------------------------------------------------
   logic [PHASE_W-1:0] durations [8];
   logic [MODE_W-1:0]  mode_of   [NUM_LEDS];
   logic [CB-1:0]      count_of  [NUM_LEDS];
   logic [PHASE_W-1:0] phase_of  [NUM_LEDS];
   logic               level_of  [NUM_LEDS];
   logic [PAIR_W-1:0]  pairs_of  [NUM_LEDS];

   stim_item_type  pending_reqs [$];     // transactions not yet driven
   led_levels_type expected_levels [$];  // predicted levels, oldest first

   int unsigned fail_count      = 0;
   int unsigned set_items       = 0;
   int unsigned tick_items      = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used   = 0;

   // a mode request to one led; a request equal to the current mode is dropped
   task automatic request_led_mode(int k, logic [MODE_W-1:0] m, logic [1:0] sys,
                                   logic srv);
      logic [MODE_W-1:0] next_mode;
      next_mode = m;
      if (k > 2 || m > MODE_OFFP5S || mode_of[k] == m) return;
      // cellular override while running with the server reachable
      if (k == int'(LED_CELLULAR) && sys == SYS_RUNNING && srv) next_mode = MODE_STEADY;
      mode_of[k]  = next_mode;
      count_of[k] = '0;
      case (next_mode)
         MODE_OFF:    begin phase_of[k] = '0; level_of[k] = 1'b0; end
         MODE_STEADY: begin phase_of[k] = '0; level_of[k] = 1'b1; end
         MODE_BLINK:  begin phase_of[k] = durations[CSR_HALF]; level_of[k] = 1'b1; end
         MODE_P250:   begin phase_of[k] = durations[CSR_QUARTER]; level_of[k] = 1'b0; end
         MODE_P1S:    begin phase_of[k] = durations[CSR_OFF_ONE]; level_of[k] = 1'b0; end
         MODE_P3S:    begin phase_of[k] = durations[CSR_OFF_THREE]; level_of[k] = 1'b0; end
         MODE_P5S:    begin phase_of[k] = durations[CSR_OFF_FIVE]; level_of[k] = 1'b0; end
         MODE_TWICE, MODE_P80: begin
            phase_of[k] = durations[CSR_OFF_SHORT];
            level_of[k] = 1'b0;
         end
         MODE_OFFP5S: begin phase_of[k] = durations[CSR_ON_FIVE]; level_of[k] = 1'b1; end
         MODE_TICKTOCK: begin
            // launched on position it re-phases the other two, counts kept
            if (k == int'(LED_POSITION)) begin
               phase_of[0] = durations[CSR_QUARTER];
               level_of[0] = 1'b0;
               mode_of[1]  = MODE_TICKTOCK;
               phase_of[1] = durations[CSR_QUARTER];
               level_of[1] = 1'b1;
               mode_of[2]  = MODE_TICKTOCK;
               phase_of[2] = durations[CSR_QUARTER];
               level_of[2] = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   // one tick of one led
   task automatic advance_led(int k);
      logic [CB-1:0] c;
      logic          lit;
      if (mode_of[k] == MODE_OFF) begin
         level_of[k] = 1'b0;
         return;
      end
      if (mode_of[k] == MODE_STEADY) begin
         level_of[k] = 1'b1;
         return;
      end
      c = count_of[k] + 1'b1;
      // phase ends at its length, or when the counter is full
      if (c < phase_of[k] && c != {CB{1'b1}}) begin
         count_of[k] = c;
         return;
      end
      count_of[k] = '0;
      level_of[k] = ~level_of[k];
      lit         = level_of[k];
      case (mode_of[k])
         MODE_P250: phase_of[k] = lit ? durations[CSR_ON_SHORT] : durations[CSR_QUARTER];
         MODE_P1S:  phase_of[k] = lit ? durations[CSR_ON_SHORT] : durations[CSR_OFF_ONE];
         MODE_P3S:  phase_of[k] = lit ? durations[CSR_ON_SHORT] : durations[CSR_OFF_THREE];
         MODE_P5S:  phase_of[k] = lit ? durations[CSR_ON_SHORT] : durations[CSR_OFF_FIVE];
         MODE_P80:  phase_of[k] = lit ? durations[CSR_ON_SHORT] : durations[CSR_OFF_SHORT];
         MODE_TICKTOCK: phase_of[k] = durations[CSR_QUARTER];
         MODE_OFFP5S: phase_of[k] = lit ? durations[CSR_ON_FIVE] : durations[CSR_ON_SHORT];
         MODE_TWICE: begin
            // two short flashes, then the one second gap
            phase_of[k] = durations[CSR_ON_SHORT];
            if (lit) begin
               pairs_of[k] = pairs_of[k] + 1'b1;
            end else if (pairs_of[k] == PAIR_END) begin
               pairs_of[k] = '0;
               phase_of[k] = durations[CSR_OFF_ONE];
            end
         end
         default: ;
      endcase
   endtask

   // whole effect of one accepted transaction, result pushed as expectation
   task automatic apply_transaction(stim_item_type r);
      if (r.op == OP_SET_MODE) begin
         request_led_mode(int'(r.sel), r.mode, r.sys, r.srv);
      end else begin
         if (r.sys == SYS_RUNNING) begin
            if (!r.err) request_led_mode(int'(LED_SYSTEM), MODE_OFF, r.sys, r.srv);
         end else if (r.sys == SYS_SLEEP || r.sys == SYS_BATTERY) begin
            request_led_mode(int'(LED_POSITION), MODE_OFF, r.sys, r.srv);
            request_led_mode(int'(LED_CELLULAR), MODE_OFF, r.sys, r.srv);
            if (!r.err)
               request_led_mode(int'(LED_SYSTEM),
                                (r.sys == SYS_SLEEP) ? MODE_P3S : MODE_STEADY, r.sys, r.srv);
         end
         if (r.err) request_led_mode(int'(LED_SYSTEM), MODE_P80, r.sys, r.srv);
         for (int k = 0; k < NUM_LEDS; k++) advance_led(k);
      end
      expected_levels.push_back('{pos_on: level_of[0], sys_on: level_of[1],
                                  cell_on: level_of[2]});
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_req(logic op, logic [1:0] sel, logic [MODE_W-1:0] mode,
                           logic [1:0] sys, logic err, logic srv);
      pending_reqs.push_back('{op: op, sel: sel, mode: mode, sys: sys, err: err, srv: srv});
   endtask

   // mostly ticks in the "other" and running states so that the leds keep blinking
   function automatic stim_item_type random_req(int unsigned set_pct);
      stim_item_type r;
      int unsigned   pick;
      r.op   = ($urandom_range(0, 99) < set_pct) ? OP_SET_MODE : OP_TICK;
      r.sel  = ($urandom_range(0, 15) == 0) ? LED_NONE : 2'($urandom_range(0, 2));
      r.mode = ($urandom_range(0, 15) == 0)
               ? MODE_W'($urandom_range(int'(MODE_OFFP5S) + 1, 15))
               : MODE_W'($urandom_range(0, int'(MODE_OFFP5S)));
      pick   = $urandom_range(0, 19);
      r.sys  = (pick < 8) ? SYS_OTHER : (pick < 14) ? SYS_RUNNING :
               (pick < 17) ? SYS_SLEEP : SYS_BATTERY;
      r.err  = ($urandom_range(0, 4) == 0);
      r.srv  = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // engine idle: nothing queued, nothing offered, nothing outstanding
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_levels.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);  // input and result registers plus margin
   endtask

   // register write at a clock edge, model updated at the same time
   task automatic write_duration(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      durations[idx] = val;
   endtask

   // ---------------------------------------------------------------------
   // driver: one transaction at a time from the pending queue, random gaps
   // ---------------------------------------------------------------------
   stim_item_type cur_req     = '0;
   int unsigned   req_gap     = 0;
   logic          req_gaps_on = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_transaction(cur_req);
            if (cur_req.op == OP_SET_MODE) set_items++;
            else tick_items++;
         end
         // slot free once the offered transaction has gone or none is offered
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               req_op           <= cur_req.op;
               req_led_select   <= cur_req.sel;
               req_mode_request <= cur_req.mode;
               req_system_mode  <= cur_req.sys;
               req_error_flag   <= cur_req.err;
               req_server_ok    <= cur_req.srv;
               req_valid        <= 1'b1;
               // occasional switch between gappy and back-to-back stretches
               if ($urandom_range(0, 59) == 0) req_gaps_on = !req_gaps_on;
               req_gap = req_gaps_on ? $urandom_range(0, 19) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks each result against the oldest prediction, random stall
   // ---------------------------------------------------------------------
   led_levels_type want;
   int unsigned    rsp_hold    = 0;
   logic           rsp_gaps_on = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_levels.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("%0t: result with no transaction pending: pos %b sys %b cell %b",
                           $realtime, rsp_position_led_on, rsp_system_led_on,
                           rsp_cellular_led_on);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_position_led_on !== want.pos_on || rsp_system_led_on !== want.sys_on ||
                   rsp_cellular_led_on !== want.cell_on) begin
                  fail_count++;
                  if (fail_count <= SHOW_LIMIT)
                     $display("%0t: led mismatch: expected pos %b sys %b cell %b, got %b %b %b",
                              $realtime, want.pos_on, want.sys_on, want.cell_on,
                              rsp_position_led_on, rsp_system_led_on, rsp_cellular_led_on);
               end
            end
            if ($urandom_range(0, 59) == 0) rsp_gaps_on = !rsp_gaps_on;
            rsp_hold = rsp_gaps_on ? $urandom_range(0, 19) : 0;
         end else if (rsp_valid && rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: ends the run when no handshake of any kind happens for long
   // ---------------------------------------------------------------------
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("[three_led_blink_pattern_engine_top] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // sequence: reset, directed transactions, then random phases
   // ---------------------------------------------------------------------
   initial begin
      logic [CSR_DATA_W-1:0] vals [8];
      int unsigned           n_items;
      int unsigned           set_pct;

      // model state after reset: default durations, every led off
      durations[CSR_ON_SHORT]  = 8'd8;
      durations[CSR_OFF_SHORT] = 8'd8;
      durations[CSR_QUARTER]   = 8'd25;
      durations[CSR_HALF]      = 8'd50;
      durations[CSR_OFF_ONE]   = 8'd100;
      durations[CSR_OFF_THREE] = 8'd255;
      durations[CSR_OFF_FIVE]  = 8'd255;
      durations[CSR_ON_FIVE]   = 8'd255;
      for (int k = 0; k < NUM_LEDS; k++) begin
         mode_of[k]  = MODE_OFF;
         count_of[k] = '0;
         phase_of[k] = '0;
         level_of[k] = 1'b0;
         pairs_of[k] = '0;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // directed part under the reset durations
      push_req(OP_SET_MODE, LED_POSITION, MODE_STEADY, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_SET_MODE, LED_SYSTEM, MODE_BLINK, SYS_OTHER, 1'b0, 1'b0);
      // cellular override turns pulse80 into steady
      push_req(OP_SET_MODE, LED_CELLULAR, MODE_P80, SYS_RUNNING, 1'b0, 1'b1);
      push_req(OP_SET_MODE, LED_CELLULAR, MODE_TWICE, SYS_OTHER, 1'b0, 1'b0);
      // same mode again changes nothing
      push_req(OP_SET_MODE, LED_CELLULAR, MODE_TWICE, SYS_OTHER, 1'b0, 1'b0);
      // bad selector and bad mode are ignored
      push_req(OP_SET_MODE, LED_NONE, MODE_BLINK, SYS_OTHER, 1'b1, 1'b1);
      push_req(OP_SET_MODE, LED_POSITION, 4'hF, SYS_OTHER, 1'b0, 1'b0);
      repeat (3) push_req(OP_TICK, LED_POSITION, MODE_OFF, SYS_OTHER, 1'b0, 1'b0);
      // ticktock on system keeps its level and phase
      push_req(OP_SET_MODE, LED_SYSTEM, MODE_TICKTOCK, SYS_OTHER, 1'b0, 1'b0);
      // ticktock on position re-phases all three
      push_req(OP_SET_MODE, LED_POSITION, MODE_TICKTOCK, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_TICK, LED_POSITION, MODE_OFF, SYS_OTHER, 1'b0, 1'b0);
      // running without error turns the system led off
      push_req(OP_TICK, LED_POSITION, MODE_OFF, SYS_RUNNING, 1'b0, 1'b0);
      // ticktock from off leaves a zero phase: toggles on the first tick
      push_req(OP_SET_MODE, LED_SYSTEM, MODE_TICKTOCK, SYS_OTHER, 1'b0, 1'b0);
      repeat (2) push_req(OP_TICK, LED_POSITION, MODE_OFF, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_TICK, LED_POSITION, MODE_OFF, SYS_RUNNING, 1'b1, 1'b1);
      push_req(OP_TICK, LED_SYSTEM, MODE_OFF, SYS_SLEEP, 1'b0, 1'b0);
      push_req(OP_TICK, LED_SYSTEM, MODE_OFF, SYS_BATTERY, 1'b0, 1'b1);
      push_req(OP_TICK, LED_SYSTEM, MODE_OFF, SYS_BATTERY, 1'b1, 1'b0);
      push_req(OP_SET_MODE, LED_POSITION, MODE_OFFP5S, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_SET_MODE, LED_SYSTEM, MODE_P250, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_SET_MODE, LED_CELLULAR, MODE_P1S, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_SET_MODE, LED_POSITION, MODE_P3S, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_SET_MODE, LED_SYSTEM, MODE_P5S, SYS_OTHER, 1'b0, 1'b0);
      push_req(OP_TICK, LED_POSITION, MODE_OFF, SYS_OTHER, 1'b0, 1'b0);

      // random phases, each under a fresh set of durations
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         for (int i = 0; i < 8; i++) begin
            case (ph)
               0:       vals[i] = 8'd1;                         // minimum everywhere
               1:       vals[i] = 8'($urandom_range(1, 6));
               2:       vals[i] = 8'd255;                       // maximum everywhere
               3:       vals[i] = 8'($urandom_range(1, 255));
               4:       vals[i] = 8'($urandom_range(1, 4));
               default: vals[i] = 8'($urandom_range(1, 20));
            endcase
            write_duration(CSR_IDX_W'(i), vals[i]);
         end
         @(posedge clock);
         csr_write <= 1'b0;
         settings_used++;
         case (ph)
            0:       begin n_items = 200; set_pct = 20; end
            1:       begin n_items = 300; set_pct = 20; end
            2:       begin n_items = 250; set_pct = 3;  end  // long phases need ticks
            3:       begin n_items = 200; set_pct = 15; end
            4:       begin n_items = 300; set_pct = 25; end
            default: begin n_items = 150; set_pct = 15; end
         endcase
         @(negedge clock);
         repeat (n_items) pending_reqs.push_back(random_req(set_pct));
      end

      // drain, then wait for any stray result
      wait_idle();
      repeat (8) @(negedge clock);
      if (expected_levels.size() != 0) fail_count++;

      $display("covered %0d transactions (%0d set-mode, %0d ticks), %0d results checked",
               set_items + tick_items, set_items, tick_items, results_checked);
      $display("under %0d duration settings, %0d failures", settings_used, fail_count);
      if (fail_count == 0) begin
         $display("[three_led_blink_pattern_engine_top] OK");
      end else begin
         $display("[three_led_blink_pattern_engine_top] ERROR");
      end
      $finish;
   end

endmodule
